>>> rtl/core/sstr_pkg.sv
package sstr_pkg;

  // Width of a table size (states squared, at most 31 * 31 entries).
  localparam int unsigned NW = 10;

  // Largest state count that the five-bit register can express.
  localparam int unsigned STATES_REG_MAX = 31;

  localparam logic signed [7:0] ID_NONE = -8'sd1;

  typedef enum logic [1:0] {
    CMD_RECORD   = 2'd0,
    CMD_HIST_RD  = 2'd1,
    CMD_TAB_RD   = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_HISTORY_LEN = 1'b0,
    REG_NUM_STATES  = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HREAD,
    ST_TREAD,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    logic signed [7:0] cur;
    logic signed [7:0] prior;
    logic [62:0]       stamp;
    logic [1:0]        why;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{cur: ID_NONE, prior: ID_NONE, stamp: '0, why: '0};

endpackage

>>> rtl/core/sstr_ram.sv
module sstr_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 81,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/state_switch_trace_recorder_top.sv
// State switch recorder. A command is transferred when start_i is high and busy_o is low.
// A record writes the history ring in the cycle it is taken, unless the history length is
// zero. When the previous state id is valid and the table size is nonzero, the block then
// walks the transition table through its single read port, one entry per cycle, and stays
// busy until it writes a matching or free entry or finds the table full; a record that
// starts no walk keeps the block free. A history or table read returns its result on
// valid_o in the cycle after the transfer when the index is out of range, else after the
// memory read and output registers. Every read gives exactly one valid_o pulse that the
// receiver must take at once; a record or an unused command gives none. An in-range read
// taken with a configuration write gives none. Reset and every configuration write start
// a clearing pass that holds busy_o high; configuration writes are still taken during it.
module state_switch_trace_recorder_top #(
  parameter int unsigned HIST_DEPTH = 8,
  parameter int unsigned MAX_STATES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [7:0]  state_id_i,
  input  logic [62:0]        stamp_i,
  input  logic [1:0]         cause_i,
  input  logic [7:0]         index_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [4:0]         cfg_data_i,
  output logic               valid_o,
  output logic               ok_o,
  output logic signed [7:0]  cur_id_o,
  output logic signed [7:0]  prior_id_o,
  output logic [62:0]        when_o,
  output logic [1:0]         why_o
);

  localparam int unsigned STATES_CAP =
      (MAX_STATES > sstr_pkg::STATES_REG_MAX) ? sstr_pkg::STATES_REG_MAX : MAX_STATES;
  localparam int unsigned TAB_DEPTH = STATES_CAP * STATES_CAP;
  localparam int unsigned TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
  localparam int unsigned HIST_AW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned HL_CAP    = (HIST_DEPTH > 15) ? 15 : HIST_DEPTH;
  localparam int unsigned CLR_LEN   = (TAB_DEPTH > HIST_DEPTH) ? TAB_DEPTH : HIST_DEPTH;
  localparam int unsigned EW        = $bits(sstr_pkg::entry_t);
  localparam int unsigned NW        = sstr_pkg::NW;

  sstr_pkg::state_e state_q, state_d;

  logic [3:0]          history_len_q;
  logic [4:0]          num_states_q;
  logic [NW-1:0]       clr_q, clr_d;
  logic [HIST_AW-1:0]  wp_q, wp_d;
  logic signed [7:0]   last_id_q, last_id_d;
  logic [NW-1:0]       srch_q, srch_d;
  logic                chk_vld_q, chk_vld_d;
  logic [NW-1:0]       chk_idx_q, chk_idx_d;
  sstr_pkg::entry_t    rec_q, rec_d;

  logic                out_valid_q, out_valid_d;
  logic                out_ok_q, out_ok_d;
  sstr_pkg::entry_t    out_q, out_d;

  logic [3:0]          hl_eff;
  logic [4:0]          sc_eff;
  logic [NW-1:0]       n_eff;
  logic                accept;
  logic [8:0]          slot_raw;
  logic [8:0]          slot;
  logic                tab_hit;

  logic                hist_we, hist_re, tab_we, tab_re;
  logic [HIST_AW-1:0]  hist_waddr, hist_raddr;
  logic [TAB_AW-1:0]   tab_waddr, tab_raddr;
  sstr_pkg::entry_t    hist_wdata, tab_wdata, hist_rdata, tab_rdata;

  sstr_ram #(
    .DEPTH (HIST_DEPTH),
    .WIDTH (EW),
    .AW    (HIST_AW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  sstr_ram #(
    .DEPTH (TAB_DEPTH),
    .WIDTH (EW),
    .AW    (TAB_AW)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .re_i    (tab_re),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  assign hl_eff = (history_len_q > 4'(HL_CAP)) ? 4'(HL_CAP) : history_len_q;
  assign sc_eff = (num_states_q > 5'(STATES_CAP)) ? 5'(STATES_CAP) : num_states_q;
  assign n_eff  = NW'(sc_eff) * NW'(sc_eff);
  assign accept = start_i && (state_q == sstr_pkg::ST_IDLE);

  // Newest entry sits just below the write pointer; count back index_i from there.
  assign slot_raw = 9'(wp_q) + 9'(hl_eff) - 9'd1 - 9'(index_i);
  assign slot     = (slot_raw >= 9'(hl_eff)) ? (slot_raw - 9'(hl_eff)) : slot_raw;

  // A free entry (id of -1) also counts as a hit.
  assign tab_hit = ((tab_rdata.cur == rec_q.cur) && (tab_rdata.prior == rec_q.prior)) ||
                   (tab_rdata.cur == sstr_pkg::ID_NONE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    wp_d        = wp_q;
    last_id_d   = last_id_q;
    srch_d      = srch_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    rec_d       = rec_q;
    out_valid_d = 1'b0;
    out_ok_d    = out_ok_q;
    out_d       = out_q;
    hist_we     = 1'b0;
    hist_waddr  = wp_q;
    hist_wdata  = sstr_pkg::ENTRY_EMPTY;
    hist_re     = 1'b0;
    hist_raddr  = HIST_AW'(slot);
    tab_we      = 1'b0;
    tab_waddr   = TAB_AW'(chk_idx_q);
    tab_wdata   = rec_q;
    tab_re      = 1'b0;
    tab_raddr   = TAB_AW'(index_i);

    unique case (state_q)
      sstr_pkg::ST_CLEAR: begin
        tab_we     = (clr_q < NW'(TAB_DEPTH));
        tab_waddr  = TAB_AW'(clr_q);
        tab_wdata  = sstr_pkg::ENTRY_EMPTY;
        hist_we    = (clr_q < NW'(HIST_DEPTH));
        hist_waddr = HIST_AW'(clr_q);
        clr_d      = clr_q + NW'(1);
        if (clr_q == NW'(CLR_LEN - 1)) begin
          state_d = sstr_pkg::ST_IDLE;
        end
      end
      sstr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            sstr_pkg::CMD_RECORD: begin
              if (hl_eff != 4'd0) begin
                hist_we    = 1'b1;
                hist_wdata = '{cur: state_id_i, prior: last_id_q, stamp: stamp_i,
                               why: cause_i};
                wp_d       = ((5'(wp_q) + 5'd1) == 5'(hl_eff)) ? '0 : wp_q + HIST_AW'(1);
                last_id_d  = state_id_i;
                if (!last_id_q[7] && (n_eff != '0)) begin
                  rec_d   = hist_wdata;
                  srch_d  = '0;
                  state_d = sstr_pkg::ST_SEARCH;
                end
              end
            end
            sstr_pkg::CMD_HIST_RD: begin
              if (9'(index_i) < 9'(hl_eff)) begin
                hist_re = 1'b1;
                state_d = sstr_pkg::ST_HREAD;
              end else begin
                out_valid_d = 1'b1;
                out_ok_d    = 1'b0;
                out_d       = '0;
              end
            end
            sstr_pkg::CMD_TAB_RD: begin
              if (NW'(index_i) < n_eff) begin
                tab_re  = 1'b1;
                state_d = sstr_pkg::ST_TREAD;
              end else begin
                out_valid_d = 1'b1;
                out_ok_d    = 1'b0;
                out_d       = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      sstr_pkg::ST_HREAD: begin
        out_valid_d = 1'b1;
        out_ok_d    = (hist_rdata.why != 2'd0);
        out_d       = out_ok_d ? hist_rdata : '0;
        state_d     = sstr_pkg::ST_IDLE;
      end
      sstr_pkg::ST_TREAD: begin
        out_valid_d = 1'b1;
        out_ok_d    = (tab_rdata.why != 2'd0);
        out_d       = out_ok_d ? tab_rdata : '0;
        state_d     = sstr_pkg::ST_IDLE;
      end
      sstr_pkg::ST_SEARCH: begin
        // Reads run one entry ahead of the compare; a hit issues no further read.
        tab_raddr = TAB_AW'(srch_q);
        if (chk_vld_q && tab_hit) begin
          tab_we  = 1'b1;
          state_d = sstr_pkg::ST_IDLE;
        end else if (srch_q < n_eff) begin
          tab_re    = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = srch_q;
          srch_d    = srch_q + NW'(1);
        end else if (!chk_vld_q) begin
          // Table full: nothing matched and nothing was free.
          state_d = sstr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sstr_pkg::ST_CLEAR;
      end
    endcase

    // A register write restarts the clearing pass and empties the ring.
    if (cfg_we_i) begin
      state_d   = sstr_pkg::ST_CLEAR;
      clr_d     = '0;
      wp_d      = '0;
      last_id_d = sstr_pkg::ID_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sstr_pkg::ST_CLEAR;
      clr_q         <= '0;
      wp_q          <= '0;
      last_id_q     <= sstr_pkg::ID_NONE;
      srch_q        <= '0;
      chk_vld_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      history_len_q <= 4'd5;
      num_states_q  <= 5'd16;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wp_q        <= wp_d;
      last_id_q   <= last_id_d;
      srch_q      <= srch_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sstr_pkg::REG_HISTORY_LEN: history_len_q <= cfg_data_i[3:0];
          sstr_pkg::REG_NUM_STATES:  num_states_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    rec_q     <= rec_d;
    out_ok_q  <= out_ok_d;
    out_q     <= out_d;
  end

  assign busy_o     = (state_q != sstr_pkg::ST_IDLE);
  assign valid_o    = out_valid_q;
  assign ok_o       = out_ok_q;
  assign cur_id_o   = out_q.cur;
  assign prior_id_o = out_q.prior;
  assign when_o     = out_q.stamp;
  assign why_o      = out_q.why;

  a_record_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == sstr_pkg::CMD_RECORD)) |=> !valid_o)
    else $error("record transfer produced a result");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ok_o) |-> ((cur_id_o == 8'sd0) && (prior_id_o == 8'sd0) &&
                           (when_o == '0) && (why_o == 2'd0)))
    else $error("failed read carries nonzero fields");

  a_wp_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hl_eff != 4'd0) |-> (5'(wp_q) < 5'(hl_eff)))
    else $error("write pointer outside the ring");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sstr_pkg::ST_SEARCH) |-> ((srch_q <= n_eff) && (n_eff != '0)))
    else $error("table walk ran past the table size");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == sstr_pkg::ST_HREAD) || (state_q == sstr_pkg::ST_TREAD)) |=> valid_o)
    else $error("memory read gave no result");

endmodule

>>> sim/tb.sv
module tb;
  import sstr_pkg::*;

  localparam int unsigned HIST_DEPTH  = 8;
  localparam int unsigned MAX_STATES  = 16;
  localparam int unsigned TAB_DEPTH   = MAX_STATES * MAX_STATES;
  localparam int unsigned QUIET_LIMIT = 4000;
  // A record with a table walk keeps the block busy while the walk runs.
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned PHASES        = 14;
  localparam int unsigned PHASE_ITEMS   = 95;
  localparam int unsigned DIR_ROWS      = 25;

  localparam logic [1:0] WHY_NONE  = 2'd0;
  localparam logic [1:0] WHY_INIT  = 2'd1;
  localparam logic [1:0] WHY_STOP  = 2'd2;
  localparam logic [1:0] WHY_ERROR = 2'd3;

  localparam logic signed [7:0] ID_MIN    = 8'sh80;
  localparam logic signed [7:0] ID_MAX    = 8'sd127;
  localparam logic [62:0]       STAMP_MAX = '1;

  typedef struct packed {
    logic   ok;
    entry_t e;
  } readout_t;

  typedef struct packed {
    cmd_e              cmd;
    logic signed [7:0] id;
    logic [62:0]       stamp;
    logic [1:0]        cause;
    logic [7:0]        index;
    logic              has_want;
    readout_t          want;
  } stim_t;

  localparam readout_t NO_READ = '0;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        cmd_i;
  logic signed [7:0] state_id_i;
  logic [62:0]       stamp_i;
  logic [1:0]        cause_i;
  logic [7:0]        index_i;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [4:0]        cfg_data_i;
  logic              valid_o;
  logic              ok_o;
  logic signed [7:0] cur_id_o;
  logic signed [7:0] prior_id_o;
  logic [62:0]       when_o;
  logic [1:0]        why_o;

  state_switch_trace_recorder_top #(
    .HIST_DEPTH(HIST_DEPTH),
    .MAX_STATES(MAX_STATES)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .cmd_i     (cmd_i),
    .state_id_i(state_id_i),
    .stamp_i   (stamp_i),
    .cause_i   (cause_i),
    .index_i   (index_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .valid_o   (valid_o),
    .ok_o      (ok_o),
    .cur_id_o  (cur_id_o),
    .prior_id_o(prior_id_o),
    .when_o    (when_o),
    .why_o     (why_o)
  );

  // Shadow copy of the recorder.
  logic [3:0]  hist_len_cfg;
  logic [4:0]  states_cfg;
  entry_t      hist_mem [HIST_DEPTH];
  entry_t      tab_mem [TAB_DEPTH];
  int unsigned wr_ptr;

  readout_t    expected_reads [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  bit          start_up;
  stim_t       dir_rows [DIR_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned active_hist();
    return (hist_len_cfg > HIST_DEPTH) ? HIST_DEPTH : int'(hist_len_cfg);
  endfunction

  function automatic int unsigned active_entries();
    int unsigned s;
    s = (states_cfg > MAX_STATES) ? MAX_STATES : int'(states_cfg);
    return s * s;
  endfunction

  function automatic void clear_trace();
    foreach (hist_mem[i]) hist_mem[i] = ENTRY_EMPTY;
    foreach (tab_mem[i]) tab_mem[i] = ENTRY_EMPTY;
    wr_ptr = 0;
  endfunction

  // Updates the shadow stores for one command and queues the read it returns.
  function automatic void trace_step(stim_t s);
    int unsigned       hl;
    int unsigned       n;
    int unsigned       wp;
    int unsigned       slot;
    logic signed [7:0] prev;
    bit                done;
    readout_t          r;
    hl = active_hist();
    n  = active_entries();
    r  = NO_READ;
    case (s.cmd)
      CMD_RECORD: begin
        if (hl != 0) begin
          wp   = wr_ptr % hl;
          prev = hist_mem[(wp + hl - 1) % hl].cur;
          hist_mem[wp] = '{cur: s.id, prior: prev, stamp: s.stamp, why: s.cause};
          wr_ptr = (wp + 1) % hl;
          if (!prev[7]) begin
            done = 1'b0;
            for (int unsigned i = 0; i < n && !done; i++) begin
              if ((tab_mem[i].cur == s.id && tab_mem[i].prior == prev) ||
                  tab_mem[i].cur == ID_NONE) begin
                tab_mem[i] = '{cur: s.id, prior: prev, stamp: s.stamp, why: s.cause};
                done = 1'b1;
              end
            end
          end
        end
      end
      CMD_HIST_RD: begin
        if (s.index < hl) begin
          slot = ((wr_ptr % hl) + 2 * hl - s.index - 1) % hl;
          if (hist_mem[slot].why != WHY_NONE) r = '{ok: 1'b1, e: hist_mem[slot]};
        end
        expected_reads = {expected_reads, r};
      end
      CMD_TAB_RD: begin
        if (s.index < n && tab_mem[s.index].why != WHY_NONE) begin
          r = '{ok: 1'b1, e: tab_mem[s.index]};
        end
        expected_reads = {expected_reads, r};
      end
      default: ;
    endcase
  endfunction

  task automatic lower_start();
    if (start_up) begin
      start_i  <= 1'b0;
      start_up  = 1'b0;
    end
  endtask

  task automatic issue(input stim_t s);
    if (!start_up) begin
      start_i  <= 1'b1;
      start_up  = 1'b1;
    end
    cmd_i      <= s.cmd;
    state_id_i <= s.id;
    stamp_i    <= s.stamp;
    cause_i    <= s.cause;
    index_i    <= s.index;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    trace_step(s);
    if (s.has_want) expected_reads[expected_reads.size() - 1] = s.want;
  endtask

  // Bursts of back-to-back transfers, then a gap; now and then a full drain.
  task automatic pace();
    int unsigned gap;
    bit          drain;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = $urandom_range(1, 16);
      drain      = ($urandom_range(0, 15) == 0);
      lower_start();
      repeat (gap) @(posedge clk_i);
      if (drain) begin
        while (expected_reads.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  task automatic settle();
    lower_start();
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input reg_e r, input logic [4:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (r == REG_HISTORY_LEN) hist_len_cfg = value[3:0];
    else states_cfg = value;
    clear_trace();
    @(posedge clk_i);
  endtask

  function automatic stim_t random_item();
    stim_t       s;
    int unsigned roll;
    int unsigned top;
    s = '0;
    roll = $urandom_range(0, 99);
    if (roll < 50) s.cmd = CMD_RECORD;
    else if (roll < 72) s.cmd = CMD_HIST_RD;
    else if (roll < 97) s.cmd = CMD_TAB_RD;
    else s.cmd = CMD_UNUSED;
    top = (states_cfg > MAX_STATES) ? MAX_STATES : int'(states_cfg);
    roll = $urandom_range(0, 19);
    if (roll < 14) s.id = 8'($urandom_range(0, top + 1));
    else if (roll < 16) s.id = ID_NONE;
    else s.id = 8'($urandom);
    roll = $urandom_range(0, 9);
    if (roll == 0) s.stamp = STAMP_MAX;
    else if (roll == 1) s.stamp = '0;
    else s.stamp = {$urandom, $urandom};
    s.cause = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(1, 3));
    if ($urandom_range(0, 9) < 2) s.index = 8'($urandom);
    else if (s.cmd == CMD_TAB_RD) s.index = 8'($urandom_range(0, top * top + 1));
    else s.index = 8'($urandom_range(0, HIST_DEPTH + 1));
    return s;
  endfunction

  always @(posedge clk_i) begin : check_reads
    readout_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_reads.size() == 0) begin
        $error("read result with no read outstanding");
        mismatches++;
      end else begin
        want = expected_reads.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok_o);
          mismatches++;
        end
        if (cur_id_o !== want.e.cur) begin
          $error("cur_id: expected %0d, got %0d", want.e.cur, cur_id_o);
          mismatches++;
        end
        if (prior_id_o !== want.e.prior) begin
          $error("prior_id: expected %0d, got %0d", want.e.prior, prior_id_o);
          mismatches++;
        end
        if (when_o !== want.e.stamp) begin
          $error("when: expected %0h, got %0h", want.e.stamp, when_o);
          mismatches++;
        end
        if (why_o !== want.e.why) begin
          $error("why: expected %0d, got %0d", want.e.why, why_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o === 1'b1 || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [3:0] hl_list [9];
    logic [4:0] sc_list [9];
    rst_ni     <= 1'b0;
    start_i    <= 1'b0;
    cmd_i      <= CMD_RECORD;
    state_id_i <= '0;
    stamp_i    <= '0;
    cause_i    <= WHY_NONE;
    index_i    <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_HISTORY_LEN;
    cfg_data_i <= '0;
    start_up     = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    hist_len_cfg = 4'd5;
    states_cfg   = 5'd16;
    clear_trace();

    hl_list = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd7, 4'd4, 4'd9};
    sc_list = '{5'd16, 5'd1, 5'd3, 5'd31, 5'd0, 5'd2, 5'd4, 5'd1, 5'd17};

    // Defaults apply: five history entries, 256 table entries.
    dir_rows = '{
      '{CMD_HIST_RD, 8'sd0,   63'd0,     WHY_NONE,  8'd0,   1'b1, NO_READ},
      '{CMD_TAB_RD,  8'sd0,   63'd0,     WHY_NONE,  8'd0,   1'b1, NO_READ},
      '{CMD_TAB_RD,  8'sd0,   63'd0,     WHY_NONE,  8'd255, 1'b1, NO_READ},
      '{CMD_UNUSED,  ID_NONE, STAMP_MAX, WHY_ERROR, 8'd255, 1'b0, NO_READ},
      '{CMD_RECORD,  8'sd0,   63'd0,     WHY_INIT,  8'd0,   1'b0, NO_READ},
      '{CMD_RECORD,  ID_MAX,  STAMP_MAX, WHY_ERROR, 8'd255, 1'b0, NO_READ},
      '{CMD_HIST_RD, 8'sd0,   63'd0,     WHY_NONE,  8'd0,   1'b1,
        '{1'b1, '{ID_MAX, 8'sd0, STAMP_MAX, WHY_ERROR}}},
      '{CMD_HIST_RD, 8'sd0,   63'd0,     WHY_NONE,  8'd1,   1'b1,
        '{1'b1, '{8'sd0, ID_NONE, 63'd0, WHY_INIT}}},
      '{CMD_TAB_RD,  8'sd0,   63'd0,     WHY_NONE,  8'd0,   1'b1,
        '{1'b1, '{ID_MAX, 8'sd0, STAMP_MAX, WHY_ERROR}}},
      '{CMD_RECORD,  ID_MIN,  63'd1,     WHY_STOP,  8'd0,   1'b0, NO_READ},
      '{CMD_RECORD,  ID_NONE, 63'd5,     WHY_STOP,  8'd0,   1'b0, NO_READ},
      // A record with cause zero reads back as an invalid entry.
      '{CMD_RECORD,  8'sd5,   63'd6,     WHY_NONE,  8'd0,   1'b0, NO_READ},
      '{CMD_HIST_RD, 8'sd0,   63'd0,     WHY_NONE,  8'd0,   1'b1, NO_READ},
      '{CMD_RECORD,  ID_MAX,  63'd77,    WHY_INIT,  8'd0,   1'b0, NO_READ},
      '{CMD_RECORD,  ID_MAX,  63'd78,    WHY_STOP,  8'd0,   1'b0, NO_READ},
      '{CMD_RECORD,  8'sd0,   63'd79,    WHY_ERROR, 8'd0,   1'b0, NO_READ},
      // Same pair as the first table entry, so that entry is overwritten.
      '{CMD_RECORD,  ID_MAX,  63'd80,    WHY_INIT,  8'd0,   1'b0, NO_READ},
      '{CMD_TAB_RD,  8'sd0,   63'd0,     WHY_NONE,  8'd0,   1'b0, NO_READ},
      '{CMD_HIST_RD, 8'sd0,   63'd0,     WHY_NONE,  8'd4,   1'b0, NO_READ},
      '{CMD_HIST_RD, 8'sd0,   63'd0,     WHY_NONE,  8'd5,   1'b1, NO_READ},
      // An id of -1 lands in the table and the next update reuses that entry.
      '{CMD_RECORD,  ID_NONE, 63'd81,    WHY_STOP,  8'd0,   1'b0, NO_READ},
      '{CMD_RECORD,  8'sd3,   63'd82,    WHY_INIT,  8'd0,   1'b0, NO_READ},
      '{CMD_RECORD,  8'sd4,   63'd83,    WHY_ERROR, 8'd0,   1'b0, NO_READ},
      '{CMD_TAB_RD,  8'sd0,   63'd0,     WHY_NONE,  8'd5,   1'b0, NO_READ},
      '{CMD_TAB_RD,  8'sd0,   63'd0,     WHY_NONE,  8'd4,   1'b0, NO_READ}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      issue(dir_rows[i]);
      pace();
    end

    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      if (p < 9) begin
        write_register(REG_HISTORY_LEN, {1'b0, hl_list[p]});
        write_register(REG_NUM_STATES, sc_list[p]);
      end else begin
        write_register(REG_NUM_STATES, 5'($urandom_range(0, 31)));
        write_register(REG_HISTORY_LEN, 5'($urandom_range(0, 15)));
      end
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        issue(random_item());
        pace();
      end
    end

    settle();
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sstr_pkg.sv
rtl/core/sstr_ram.sv
rtl/core/state_switch_trace_recorder_top.sv
sim/tb.sv
